// ----- hdl/sorted_priority_queue_top_macros.svh -----
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Plain property under clk_i, disabled in reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
// Package with types and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned OccW  = 5;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_EXTRACT
  } op_e;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] prio;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t new_entry;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/spq_cell.sv -----
// One slot of the sorted shift chain: holds an entry, shifts left or right.
`default_nettype none
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_gt_i,
  input  spq_pkg::entry_t    right_i,
  input  logic               occ_i,
  output spq_pkg::entry_t    entry_o,
  output logic               gt_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  assign gt_o    = occ_i && ($signed(entry_q.prio) > $signed(ctl_i.new_entry.prio));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (left_gt_i) begin
          entry_d = left_i;
        end else if (gt_o || !occ_i) begin
          entry_d = ctl_i.new_entry;
        end
      end
      OP_EXTRACT: entry_d = right_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// ----- hdl/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: cell chain, count and result register.
//
//   beat      direction  handshake                fields
//   command   in         in_valid_i / in_stall_o  cmd_i, item_value_i, item_priority_i
//   result    out        out_valid_o / out_stall_i out_value_o, status_o, occupancy_o
//
// One command per cycle while in_stall_o is low; its result is registered and shows in the next cycle.
// All cells compare against the new priority and shift in the same cycle.
// Reset clears the entry count and the result valid; slot contents are not cleared.
// in_stall_o is high only while a result waits and out_stall_i is high.
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"
module sorted_priority_queue_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic signed [31:0]       item_value_i,
  input  logic signed [31:0]       item_priority_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       out_value_o,
  output spq_pkg::status_e         status_o,
  output logic [spq_pkg::OccW-1:0] occupancy_o
);
  import spq_pkg::*;

  logic            in_acc;
  logic            full, empty;
  logic [CntW-1:0] count_q, count_d;
  cell_ctl_t       ctl;
  status_e         status_d;
  logic [31:0]     value_d;
  entry_t          ent [DEPTH];
  logic            gt  [DEPTH];
  logic            occ [DEPTH];

  logic            out_valid_q;
  logic [31:0]     out_value_q;
  status_e         status_q;
  logic [OccW-1:0] occ_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctl.op              = OP_HOLD;
    ctl.new_entry.value = item_value_i;
    ctl.new_entry.prio  = item_priority_i;
    status_d            = ST_OK;
    count_d             = count_q;
    if (in_acc) begin
      if (cmd_e'(cmd_i) == CMD_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.op  = OP_INSERT;
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctl.op  = OP_EXTRACT;
          count_d = count_q - CntW'(1);
        end
      end
    end
    value_d = (ctl.op == OP_EXTRACT) ? ent[0].value : 32'd0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_q);
    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .left_i    ((i == 0) ? ctl.new_entry : ent[(i == 0) ? 0 : i - 1]),
      .left_gt_i ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .right_i   ((i == DEPTH - 1) ? ent[i] : ent[(i == DEPTH - 1) ? i : i + 1]),
      .occ_i     (occ[i]),
      .entry_o   (ent[i]),
      .gt_o      (gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q <= value_d;
      status_q    <= status_d;
      occ_q       <= OccW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = $signed(out_value_q);
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "entry count above depth")
  `SPQ_ASSERT_IMP(a_head_sorted, count_q >= CntW'(2),
                  !($signed(ent[0].prio) > $signed(ent[1].prio)), "head pair out of order")
  `SPQ_ASSERT_NXT(a_empty_flag, in_acc && cmd_i && empty,
                  status_o == ST_EMPTY && count_q == '0, "extract from empty not flagged")
  `SPQ_ASSERT_NXT(a_insert_count, in_acc && !cmd_i && !full,
                  count_q == $past(count_q) + CntW'(1), "insert did not grow count")

endmodule
`default_nettype wire
